// ===== src/four_axis_incremental_pid_mixer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the four-axis incremental PID mixer
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FOUR_AXIS_INCREMENTAL_PID_MIXER_MACROS_SVH
`define FOUR_AXIS_INCREMENTAL_PID_MIXER_MACROS_SVH
`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define FAPM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Consequent holds in the cycle after the antecedent.
`define FAPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FAPM_ASSERT(lbl, clk, rst_n, prop, msg)
`define FAPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/fapm_pkg.sv =====
// ----------------------------------------------------------------------------
// fapm_pkg
// Types, widths and helpers shared by the PID lanes, the mixer and the top.
// ----------------------------------------------------------------------------
package fapm_pkg;

  localparam int DATA_W   = 16;
  localparam int GAIN_W   = 16;
  localparam int NUM_AXES = 4;
  localparam int CFG_W    = GAIN_W * NUM_AXES;
  localparam int CFG_IDX_W = 2;

  // Product widths: gain times error change, second difference and error.
  localparam int DERR_W = DATA_W + 1;
  localparam int SDIF_W = DATA_W + 3;
  localparam int PP_W   = GAIN_W + DERR_W;
  localparam int PV_W   = GAIN_W + SDIF_W;
  localparam int PI_W   = GAIN_W + DATA_W;
  localparam int ACC_W  = PV_W + 2;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [GAIN_W-1:0] gain_t;
  typedef data_t [NUM_AXES-1:0]     axes_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAINS  = 2'd0,
    REG_DERIV_GAINS = 2'd1,
    REG_INTEG_GAINS = 2'd2
  } cfg_reg_e;

  localparam logic [CFG_W-1:0] PROP_GAINS_RST  = 64'd1125908496910488;
  localparam logic [CFG_W-1:0] DERIV_GAINS_RST = 64'd1125908496908290;
  localparam logic [CFG_W-1:0] INTEG_GAINS_RST = 64'd1125908496908290;

  // Pipeline stage loads handed to each lane.
  typedef struct packed {
    logic prod_load;
    logic acc_load;
  } lane_ctrl_t;

  localparam logic signed [ACC_W-1:0] DATA_MAX =
    ACC_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] DATA_MIN = -DATA_MAX - ACC_W'(1);

  // Clamp a wide signed value to the signed data range.
  function automatic data_t sat_data(input logic signed [ACC_W-1:0] v);
    data_t r;
    if (v > DATA_MAX) begin
      r = DATA_MAX[DATA_W-1:0];
    end else if (v < DATA_MIN) begin
      r = DATA_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/fapm_lane.sv =====
// ----------------------------------------------------------------------------
// fapm_lane
// One axis of the velocity-form PID: products in the first stage, saturating
// accumulator update in the second.
// ----------------------------------------------------------------------------
module fapm_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fapm_pkg::lane_ctrl_t ctrl_i,
  input  fapm_pkg::data_t    position_i,
  input  fapm_pkg::data_t    reference_i,
  input  fapm_pkg::gain_t    kp_i,
  input  fapm_pkg::gain_t    kv_i,
  input  fapm_pkg::gain_t    ki_i,
  output fapm_pkg::data_t    action_o
);
  import fapm_pkg::*;

  data_t prev_err_q, pos_d1_q, pos_d2_q, acc_q;
  data_t err;
  logic signed [DERR_W-1:0] err_delta;
  logic signed [SDIF_W-1:0] sec_diff;
  logic signed [PP_W-1:0]   prod_p_d, prod_p_q;
  logic signed [PV_W-1:0]   prod_v_d, prod_v_q;
  logic signed [PI_W-1:0]   prod_i_d, prod_i_q;
  logic signed [ACC_W-1:0]  acc_sum;
  data_t acc_d;

  always_comb begin
    err       = sat_data(ACC_W'(reference_i) - ACC_W'(position_i));
    err_delta = DERR_W'(err) - DERR_W'(prev_err_q);
    sec_diff  = SDIF_W'(position_i) - (SDIF_W'(pos_d1_q) <<< 1) + SDIF_W'(pos_d2_q);
    prod_p_d  = PP_W'(kp_i) * PP_W'(err_delta);
    prod_v_d  = PV_W'(kv_i) * PV_W'(sec_diff);
    prod_i_d  = PI_W'(ki_i) * PI_W'(err);
  end

  // The error and position history advance with each accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      pos_d1_q   <= '0;
      pos_d2_q   <= '0;
    end else if (ctrl_i.prod_load) begin
      prev_err_q <= err;
      pos_d1_q   <= position_i;
      pos_d2_q   <= pos_d1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.prod_load) begin
      prod_p_q <= prod_p_d;
      prod_v_q <= prod_v_d;
      prod_i_q <= prod_i_d;
    end
  end

  always_comb begin
    acc_sum = ACC_W'(acc_q) + ACC_W'(prod_p_q) + ACC_W'(prod_v_q) + ACC_W'(prod_i_q);
    acc_d   = sat_data(acc_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_load) begin
      acc_q <= acc_d;
    end
  end

  assign action_o = acc_q;

endmodule

// ===== src/fapm_mix.sv =====
// ----------------------------------------------------------------------------
// fapm_mix
// Quad mixer: quarters the four axis actions and forms the motor duties
// in the output register.
// ----------------------------------------------------------------------------
module fapm_mix (
  input  logic                 clk_i,
  input  logic                 load_i,
  input  fapm_pkg::axes_data_t action_i,
  output fapm_pkg::axes_data_t duty_o
);
  import fapm_pkg::*;

  axes_data_t q;
  axes_data_t duty_d, duty_q;

  // Four quartered actions always fit the data range, so no clamp is needed.
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      q[i] = action_i[i] >>> 2;
    end
    duty_d[0] =  q[0] + q[1] + q[2] + q[3];
    duty_d[1] =  q[0] - q[1] - q[2] + q[3];
    duty_d[2] = -q[0] - q[1] + q[2] + q[3];
    duty_d[3] = -q[0] + q[1] - q[2] + q[3];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      duty_q <= duty_d;
    end
  end

  assign duty_o = duty_q;

endmodule

// ===== src/four_axis_incremental_pid_mixer.sv =====
// ----------------------------------------------------------------------------
// four_axis_incremental_pid_mixer
// Four-lane velocity-form PID controller with a quad-rotor mixer.
// ----------------------------------------------------------------------------
// Each accepted word runs through three registered stages: the four lanes
// form their gain products, then update their saturating accumulators, and
// the mixer registers the four motor duties; out_valid_o rises once the word
// is in the output register. A new word is accepted every cycle unless
// in_stall_o is high. The state loops (the error and position history in
// the first stage, the accumulator in the second) each close within their
// own stage. Gains are to be written by the user through the plain write
// port only while the pipeline is empty; the block does not enforce this.
// A write to an index beyond the three gain registers is dropped.
module four_axis_incremental_pid_mixer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fapm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fapm_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  fapm_pkg::data_t                   position_0_i,
  input  fapm_pkg::data_t                   position_1_i,
  input  fapm_pkg::data_t                   position_2_i,
  input  fapm_pkg::data_t                   position_3_i,
  input  fapm_pkg::data_t                   reference_0_i,
  input  fapm_pkg::data_t                   reference_1_i,
  input  fapm_pkg::data_t                   reference_2_i,
  input  fapm_pkg::data_t                   reference_3_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output fapm_pkg::data_t                   duty_motor_0_o,
  output fapm_pkg::data_t                   duty_motor_1_o,
  output fapm_pkg::data_t                   duty_motor_2_o,
  output fapm_pkg::data_t                   duty_motor_3_o
);
  import fapm_pkg::*;
  `include "four_axis_incremental_pid_mixer_macros.svh"

  logic [CFG_W-1:0] prop_gains_q, deriv_gains_q, integ_gains_q;
  logic prod_vld_q, acc_vld_q, out_vld_q;
  logic out_rdy, acc_rdy, prod_rdy, in_accept;
  lane_ctrl_t lane_ctrl;
  axes_data_t position, reference, action, duty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gains_q  <= PROP_GAINS_RST;
      deriv_gains_q <= DERIV_GAINS_RST;
      integ_gains_q <= INTEG_GAINS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PROP_GAINS:  prop_gains_q  <= cfg_data_i;
        REG_DERIV_GAINS: deriv_gains_q <= cfg_data_i;
        REG_INTEG_GAINS: integ_gains_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or its word moves on this cycle.
  assign out_rdy   = !out_vld_q || !out_stall_i;
  assign acc_rdy   = !acc_vld_q || out_rdy;
  assign prod_rdy  = !prod_vld_q || acc_rdy;
  assign in_stall_o = !prod_rdy;
  assign in_accept = in_valid_i && prod_rdy;

  assign lane_ctrl.prod_load = in_accept;
  assign lane_ctrl.acc_load  = prod_vld_q && acc_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (prod_rdy) prod_vld_q <= in_valid_i;
      if (acc_rdy)  acc_vld_q  <= prod_vld_q;
      if (out_rdy)  out_vld_q  <= acc_vld_q;
    end
  end

  assign position  = '{position_3_i, position_2_i, position_1_i, position_0_i};
  assign reference = '{reference_3_i, reference_2_i, reference_1_i, reference_0_i};

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    fapm_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (lane_ctrl),
      .position_i  (position[g]),
      .reference_i (reference[g]),
      .kp_i        (gain_t'(prop_gains_q[g*GAIN_W +: GAIN_W])),
      .kv_i        (gain_t'(deriv_gains_q[g*GAIN_W +: GAIN_W])),
      .ki_i        (gain_t'(integ_gains_q[g*GAIN_W +: GAIN_W])),
      .action_o    (action[g])
    );
  end

  fapm_mix u_mix (
    .clk_i    (clk_i),
    .load_i   (acc_vld_q && out_rdy),
    .action_i (action),
    .duty_o   (duty)
  );

  assign out_valid_o    = out_vld_q;
  assign duty_motor_0_o = duty[0];
  assign duty_motor_1_o = duty[1];
  assign duty_motor_2_o = duty[2];
  assign duty_motor_3_o = duty[3];

  // Backpressure reaches the input only when every stage holds a word.
  `FAPM_ASSERT(a_stall_full, clk_i, rst_ni,
    !in_stall_o || (prod_vld_q && acc_vld_q && out_vld_q),
    "input stalled with an empty stage")
  // An accepted word always occupies the product stage next cycle.
  `FAPM_ASSERT_NEXT(a_accept_fills, clk_i, rst_ni, in_valid_i && !in_stall_o,
    prod_vld_q, "accepted word lost")
  // The output cannot become valid without a word in the accumulator stage.
  `FAPM_ASSERT_NEXT(a_no_invent, clk_i, rst_ni,
    !acc_vld_q && (!out_vld_q || !out_stall_i), !out_valid_o,
    "result without a source word")

endmodule

// ===== test/four_axis_incremental_pid_mixer_tb.sv =====
// ----------------------------------------------------------------------------
// four_axis_incremental_pid_mixer_tb
// Self-checking bench for the four-axis incremental PID mixer. A driver feeds
// control ticks in random bursts, and a monitor stalls the duty output and
// compares every duty word with a cycle-free model of the four PID lanes
// and the mixer. The gain registers are rewritten between phases while the
// pipeline is empty.
// ----------------------------------------------------------------------------
module four_axis_incremental_pid_mixer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fapm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    axes_data_t position;
    axes_data_t reference;
  } tick_word_t;

  typedef enum logic [1:0] {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  data_t                position_0_i = '0;
  data_t                position_1_i = '0;
  data_t                position_2_i = '0;
  data_t                position_3_i = '0;
  data_t                reference_0_i = '0;
  data_t                reference_1_i = '0;
  data_t                reference_2_i = '0;
  data_t                reference_3_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  data_t                duty_motor_0_o;
  data_t                duty_motor_1_o;
  data_t                duty_motor_2_o;
  data_t                duty_motor_3_o;

  four_axis_incremental_pid_mixer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .position_0_i   (position_0_i),
    .position_1_i   (position_1_i),
    .position_2_i   (position_2_i),
    .position_3_i   (position_3_i),
    .reference_0_i  (reference_0_i),
    .reference_1_i  (reference_1_i),
    .reference_2_i  (reference_2_i),
    .reference_3_i  (reference_3_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .duty_motor_0_o (duty_motor_0_o),
    .duty_motor_1_o (duty_motor_1_o),
    .duty_motor_2_o (duty_motor_2_o),
    .duty_motor_3_o (duty_motor_3_o)
  );

  // Gain registers and per-axis controller state as the block should hold them.
  logic [CFG_W-1:0] gain_reg [3];
  data_t            prev_err [NUM_AXES] = '{default: '0};
  data_t            pos_d1   [NUM_AXES] = '{default: '0};
  data_t            pos_d2   [NUM_AXES] = '{default: '0};
  data_t            action   [NUM_AXES] = '{default: '0};

  tick_word_t tick_q [$];
  axes_data_t duty_q [$];
  int         ticks_queued = 0;
  int         ticks_taken = 0;
  int         duties_seen = 0;
  int         fail_count = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp_to_data(longint v);
    longint hi;
    hi = (longint'(1) <<< (DATA_W - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Advances the lane state by one tick and returns the four mixed duties.
  function automatic axes_data_t predict_duties(tick_word_t w);
    axes_data_t duty;
    longint     pos, err, acc, kp, kv, ki;
    longint     q [NUM_AXES];
    longint     mix [NUM_AXES];
    for (int i = 0; i < NUM_AXES; i++) begin
      pos = $signed(w.position[i]);
      err = clamp_to_data(longint'($signed(w.reference[i])) - pos);
      kp  = $signed(gain_reg[REG_PROP_GAINS][GAIN_W*i +: GAIN_W]);
      kv  = $signed(gain_reg[REG_DERIV_GAINS][GAIN_W*i +: GAIN_W]);
      ki  = $signed(gain_reg[REG_INTEG_GAINS][GAIN_W*i +: GAIN_W]);
      acc = longint'(action[i]) + kp * (err - longint'(prev_err[i]))
          + kv * (pos - 2 * longint'(pos_d1[i]) + longint'(pos_d2[i])) + ki * err;
      acc = clamp_to_data(acc);
      action[i]   = data_t'(acc);
      prev_err[i] = data_t'(err);
      pos_d2[i]   = pos_d1[i];
      pos_d1[i]   = data_t'(pos);
      q[i] = acc >>> 2;
    end
    mix[0] =  q[0] + q[1] + q[2] + q[3];
    mix[1] =  q[0] - q[1] - q[2] + q[3];
    mix[2] = -q[0] - q[1] + q[2] + q[3];
    mix[3] = -q[0] + q[1] - q[2] + q[3];
    for (int i = 0; i < NUM_AXES; i++) begin
      duty[i] = data_t'(clamp_to_data(mix[i]));
    end
    return duty;
  endfunction

  function automatic data_t rand_field();
    case ($urandom_range(0, 7))
      0: return data_t'(16'h7FFF);
      1: return data_t'(16'h8000);
      2: return '0;
      3: return '1;
      4: return data_t'(int'($urandom_range(0, 64)) - 32);
      default: return data_t'($urandom);
    endcase
  endfunction

  // Four signed gains, one per lane, drawn from the corner values.
  function automatic logic [CFG_W-1:0] corner_gains();
    logic [CFG_W-1:0] g;
    for (int i = 0; i < NUM_AXES; i++) begin
      case ($urandom_range(0, 4))
        0: g[GAIN_W*i +: GAIN_W] = 16'h7FFF;
        1: g[GAIN_W*i +: GAIN_W] = 16'h8000;
        2: g[GAIN_W*i +: GAIN_W] = 16'h0000;
        3: g[GAIN_W*i +: GAIN_W] = 16'h0001;
        default: g[GAIN_W*i +: GAIN_W] = 16'hFFFF;
      endcase
    end
    return g;
  endfunction

  function automatic logic [CFG_W-1:0] modest_gains();
    logic [CFG_W-1:0] g;
    for (int i = 0; i < NUM_AXES; i++) begin
      g[GAIN_W*i +: GAIN_W] = GAIN_W'(int'($urandom_range(0, 16)) - 8);
    end
    return g;
  endfunction

  task automatic write_gains(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_PROP_GAINS:  gain_reg[REG_PROP_GAINS] = val;
      REG_DERIV_GAINS: gain_reg[REG_DERIV_GAINS] = val;
      REG_INTEG_GAINS: gain_reg[REG_INTEG_GAINS] = val;
      default: ;
    endcase
  endtask

  task automatic push_tick(tick_word_t w);
    tick_q.push_back(w);
    ticks_queued++;
  endtask

  task automatic push_uniform(data_t pos, data_t ref_val, int reps);
    tick_word_t w;
    for (int i = 0; i < NUM_AXES; i++) begin
      w.position[i]  = pos;
      w.reference[i] = ref_val;
    end
    repeat (reps) push_tick(w);
  endtask

  // Mostly plant-like trajectories that settle toward a setpoint, with
  // setpoint jumps and some words of pure noise mixed in.
  task automatic queue_ticks(int count);
    tick_word_t w;
    longint     walk_pos [NUM_AXES];
    longint     walk_ref [NUM_AXES];
    for (int i = 0; i < NUM_AXES; i++) begin
      walk_pos[i] = $signed(rand_field());
      walk_ref[i] = $signed(rand_field());
    end
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          w.position[i]  = rand_field();
          w.reference[i] = rand_field();
        end
      end else begin
        for (int i = 0; i < NUM_AXES; i++) begin
          if ($urandom_range(0, 19) == 0) walk_ref[i] = $signed(rand_field());
          walk_pos[i] = clamp_to_data(walk_pos[i] + (walk_ref[i] - walk_pos[i]) / 8
                                      + int'($urandom_range(0, 32)) - 16);
          w.position[i]  = data_t'(walk_pos[i]);
          w.reference[i] = data_t'(walk_ref[i]);
        end
      end
      push_tick(w);
    end
  endtask

  // The sender holds back until every duty word is home and the pipe is empty.
  task automatic wait_idle();
    while (ticks_taken != ticks_queued || duty_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    tick_word_t w;
    gain_reg[REG_PROP_GAINS]  = PROP_GAINS_RST;
    gain_reg[REG_DERIV_GAINS] = DERIV_GAINS_RST;
    gain_reg[REG_INTEG_GAINS] = INTEG_GAINS_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words under the reset gains.
    push_uniform('0, '0, 1);
    push_uniform(data_t'(16'h8000), data_t'(16'h7FFF), 3);
    push_uniform(data_t'(16'h7FFF), data_t'(16'h8000), 3);
    push_uniform(data_t'(16'h7FFF), data_t'(16'h7FFF), 1);
    push_uniform(data_t'(16'h8000), data_t'(16'h8000), 1);
    push_uniform(data_t'(16'h7FFF), '0, 1);
    push_uniform(data_t'(16'h8000), '0, 1);
    push_uniform(data_t'(16'h7FFF), '0, 1);
    push_uniform(data_t'(16'h8000), '0, 1);
    // Small negative actions check that the quartering rounds down.
    push_uniform('0, '0, 2);
    push_uniform(data_t'(1), '0, 1);
    push_uniform(data_t'(3), data_t'(2), 1);
    push_uniform('0, data_t'(-1), 1);
    for (int i = 0; i < NUM_AXES; i++) begin
      w.position[i]  = (i % 2 == 0) ? data_t'(16'h7FFF) : data_t'(16'h8000);
      w.reference[i] = (i % 2 == 0) ? data_t'(16'h8000) : data_t'(16'h7FFF);
    end
    push_tick(w);
    w.position  = {data_t'(-1), data_t'(0), data_t'(16'h8000), data_t'(16'h7FFF)};
    w.reference = {data_t'(0), data_t'(-1), data_t'(16'h7FFF), data_t'(16'h8000)};
    push_tick(w);
    queue_ticks(140);
    wait_idle();

    write_gains(REG_PROP_GAINS,  {NUM_AXES{16'h7FFF}});
    write_gains(REG_DERIV_GAINS, {NUM_AXES{16'h7FFF}});
    write_gains(REG_INTEG_GAINS, {NUM_AXES{16'h7FFF}});
    queue_ticks(145);
    wait_idle();

    write_gains(REG_PROP_GAINS,  {NUM_AXES{16'h8000}});
    write_gains(REG_DERIV_GAINS, {NUM_AXES{16'h8000}});
    write_gains(REG_INTEG_GAINS, {NUM_AXES{16'h8000}});
    queue_ticks(145);
    wait_idle();

    write_gains(REG_PROP_GAINS,  '0);
    write_gains(REG_DERIV_GAINS, '0);
    write_gains(REG_INTEG_GAINS, '0);
    queue_ticks(145);
    wait_idle();

    write_gains(REG_PROP_GAINS,  modest_gains());
    write_gains(REG_DERIV_GAINS, modest_gains());
    write_gains(REG_INTEG_GAINS, modest_gains());
    queue_ticks(145);
    wait_idle();

    write_gains(REG_PROP_GAINS,  {$urandom, $urandom});
    write_gains(REG_DERIV_GAINS, {$urandom, $urandom});
    write_gains(REG_INTEG_GAINS, {$urandom, $urandom});
    queue_ticks(145);
    wait_idle();

    write_gains(REG_PROP_GAINS,  corner_gains());
    write_gains(REG_DERIV_GAINS, corner_gains());
    write_gains(REG_INTEG_GAINS, corner_gains());
    queue_ticks(145);
    wait_idle();

    // A write past the last gain register must leave the gains alone.
    write_gains(REG_PROP_GAINS,  modest_gains());
    write_gains(REG_UNUSED,      {$urandom, $urandom});
    queue_ticks(145);
    wait_idle();

    write_gains(REG_PROP_GAINS,  PROP_GAINS_RST);
    write_gains(REG_DERIV_GAINS, DERIV_GAINS_RST);
    write_gains(REG_INTEG_GAINS, modest_gains());
    write_gains(REG_UNUSED,      '1);
    queue_ticks(145);
    wait_idle();

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("four_axis_incremental_pid_mixer_tb passed");
    end else begin
      $display("four_axis_incremental_pid_mixer_tb failed");
    end
    $finish;
  end

  // Driver: offers ticks in bursts of random length with random gaps.
  tick_word_t cur_word;
  int         burst_left = 0;
  int         gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        duty_q.push_back(predict_duties(cur_word));
        ticks_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (tick_q.size() != 0) begin
          cur_word = tick_q.pop_front();
          position_0_i  <= cur_word.position[0];
          position_1_i  <= cur_word.position[1];
          position_2_i  <= cur_word.position[2];
          position_3_i  <= cur_word.position[3];
          reference_0_i <= cur_word.reference[0];
          reference_1_i <= cur_word.reference[1];
          reference_2_i <= cur_word.reference[2];
          reference_3_i <= cur_word.reference[3];
          in_valid_i    <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4: gap_left = 0;
              5, 6, 7:       gap_left = $urandom_range(1, 3);
              8:             gap_left = $urandom_range(4, 12);
              default:       gap_left = $urandom_range(20, 40);
            endcase
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each duty word and stalls the output on its own pattern.
  rx_mode_e   rx_mode = RX_FLOW;
  int         mode_left = 0;
  int         hold_left = 0;
  int         rx_cycle = 0;
  axes_data_t got_duty;
  axes_data_t want_duty;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      rx_cycle++;
      if (out_valid_o && !out_stall_i) begin
        got_duty = {duty_motor_3_o, duty_motor_2_o, duty_motor_1_o, duty_motor_0_o};
        if (duty_q.size() == 0) begin
          $error("duty word with no tick pending: %h", got_duty);
          fail_count++;
        end else begin
          want_duty = duty_q.pop_front();
          for (int i = 0; i < NUM_AXES; i++) begin
            if (got_duty[i] !== want_duty[i]) begin
              $error("duty_motor_%0d: expected %0d, actual %0d", i,
                     want_duty[i], got_duty[i]);
              fail_count++;
            end
          end
        end
        duties_seen++;
        // Long hold-offs let the pipe fill so the input has to stall.
        if (duties_seen == 250 || duties_seen == 1000) hold_left = 120;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 80);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_FLOW:  out_stall_i <= 1'b0;
          RX_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:  out_stall_i <= ((rx_cycle % 5) < 2);
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("four_axis_incremental_pid_mixer_tb failed");
    $finish;
  end

endmodule
